@@ rtl/core/sfl_pkg.sv @@
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared types and constants for strip/fan to triangle list assembly.
// ----------------------------------------------------------------------------
package sfl_pkg;

	// Vertex index width and vertex count register width
	localparam int IndexBits = 16;
	localparam int CountBits = IndexBits + 1;

	// Stream payload widths (byte aligned tdata)
	localparam int STDataBits = ((2 + IndexBits + 7) / 8) * 8;
	localparam int STUserBits = 3;
	localparam int MTDataBits = ((IndexBits + 7) / 8) * 8;

	// Queue between front and back
	localparam int QDepth    = 4;
	localparam int QAddrBits = $clog2(QDepth);
	localparam int QCntBits  = $clog2(QDepth + 1);

	// Event opcodes
	localparam logic [1:0] OpBegin  = 2'd0;
	localparam logic [1:0] OpVertex = 2'd1;
	localparam logic [1:0] OpEnd    = 2'd2;

	// Primitive modes
	localparam logic [1:0] ModeList  = 2'd0;
	localparam logic [1:0] ModeStrip = 2'd1;
	localparam logic [1:0] ModeFan   = 2'd2;
	localparam logic [1:0] ModeOther = 2'd3;

	// One queued job: a single index, or a triangle of three
	typedef struct packed {
		logic [IndexBits-1:0] idx0;
		logic [IndexBits-1:0] idx1;
		logic [IndexBits-1:0] idx2;
		logic                 three;
	} sfl_entry_t;

	// Queue status seen by front and checks
	typedef struct packed {
		logic                empty;
		logic                full;
		logic [QCntBits-1:0] count;
	} sfl_qstat_t;

endpackage

@@ rtl/core/sfl_front.sv @@
// ----------------------------------------------------------------------------
// sfl_front
// Accepts events, tracks primitive state and queues index jobs.
// ----------------------------------------------------------------------------
module sfl_front import sfl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [1:0]           prim_mode,
	input  logic [IndexBits-1:0] vertex_index,
	input  logic                 index_present,
	input  logic                 cfg_we,
	input  logic [CountBits-1:0] cfg_value,
	input  sfl_qstat_t           qstat,
	output logic                 push,
	output sfl_entry_t           push_entry
);

	logic [CountBits-1:0] vcount_q;
	logic [1:0]           cur_mode_q;
	logic [1:0]           held_count_q;
	logic [IndexBits-1:0] held_first_q;
	logic [IndexBits-1:0] held_second_q;
	logic                 parity_q;

	logic                 accept;
	logic                 is_vertex;
	logic [IndexBits-1:0] sid;

	assign in_ready  = !qstat.full;
	assign accept    = in_valid && in_ready;
	assign is_vertex = (opcode == OpVertex) && index_present;

	// Out of range indices read as zero
	assign sid = ({1'b0, vertex_index} >= vcount_q) ? '0 : vertex_index;

	// Classify: what gets queued for this event
	always_comb begin
		push       = 1'b0;
		push_entry = '{idx0: sid, idx1: '0, idx2: '0, three: 1'b0};
		if (accept && is_vertex) begin
			unique case (cur_mode_q)
				ModeList: begin
					push = 1'b1;
				end
				ModeStrip, ModeFan: begin
					if (held_count_q == 2'd2) begin
						push       = 1'b1;
						push_entry = '{idx0: held_first_q, idx1: held_second_q,
						               idx2: sid, three: 1'b1};
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CountBits'(1 << IndexBits);
		end else if (cfg_we) begin
			vcount_q <= cfg_value;
		end
	end

	// Primitive state; unknown opcodes and absent indices change nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q    <= ModeOther;
			held_count_q  <= 2'd0;
			held_first_q  <= '0;
			held_second_q <= '0;
			parity_q      <= 1'b0;
		end else if (accept) begin
			if (opcode == OpBegin) begin
				cur_mode_q   <= prim_mode;
				held_count_q <= 2'd0;
			end else if (opcode == OpEnd) begin
				held_count_q <= 2'd0;
			end else if (is_vertex &&
			             (cur_mode_q == ModeStrip || cur_mode_q == ModeFan)) begin
				if (held_count_q != 2'd2) begin
					// filling the first two slots
					if (held_count_q == 2'd0) begin
						held_first_q <= sid;
					end else begin
						held_second_q <= sid;
					end
					held_count_q <= held_count_q + 2'd1;
					if (cur_mode_q == ModeStrip) begin
						parity_q <= 1'b0;
					end
				end else if (cur_mode_q == ModeStrip) begin
					// strip: alternate the replaced slot to keep winding
					if (!parity_q) begin
						held_first_q <= sid;
					end else begin
						held_second_q <= sid;
					end
					parity_q <= !parity_q;
				end else begin
					held_second_q <= sid;
				end
			end
		end
	end

endmodule

@@ rtl/core/sfl_queue.sv @@
// ----------------------------------------------------------------------------
// sfl_queue
// Short job queue that decouples the front from the output sequencer.
// ----------------------------------------------------------------------------
module sfl_queue import sfl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sfl_entry_t push_entry,
	input  logic       pop,
	output sfl_entry_t head,
	output sfl_qstat_t qstat
);

	sfl_entry_t           mem [QDepth];
	logic [QAddrBits-1:0] wr_ptr_q;
	logic [QAddrBits-1:0] rd_ptr_q;
	logic [QCntBits-1:0]  count_q;

	assign head        = mem[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == QCntBits'(QDepth));

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAddrBits'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAddrBits'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCntBits'(1);
				2'b01:   count_q <= count_q - QCntBits'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/sfl_back.sv @@
// ----------------------------------------------------------------------------
// sfl_back
// Walks queued jobs, one index per unstalled cycle, into the output register.
// ----------------------------------------------------------------------------
module sfl_back import sfl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfl_entry_t           head,
	input  sfl_qstat_t           qstat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IndexBits-1:0] out_index,
	output logic                 last_of_run
);

	logic [1:0]           pos_q;
	logic                 load;
	logic                 sel_last;
	logic [IndexBits-1:0] sel_index;

	assign load     = !qstat.empty && (!out_valid || out_ready);
	assign sel_last = !head.three || (pos_q == 2'd2);
	assign pop      = load && sel_last;

	// Pick the index at the current position of the head job
	always_comb begin
		unique case (pos_q)
			2'd0:    sel_index = head.idx0;
			2'd1:    sel_index = head.idx1;
			default: sel_index = head.idx2;
		endcase
	end

	// Position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				pos_q     <= pop ? 2'd0 : pos_q + 2'd1;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_index   <= sel_index;
			last_of_run <= sel_last;
		end
	end

endmodule

@@ rtl/core/strip_fan_to_triangle_list.sv @@
// ----------------------------------------------------------------------------
// strip_fan_to_triangle_list
// Primitive assembly: begin/vertex/end events in, triangle index list out.
// ----------------------------------------------------------------------------
// An input transfer is taken whenever the four-entry job queue has room;
// begin and end events and ignored vertices produce no output. A list
// vertex yields one output index, a strip or fan vertex after the first two
// yields a triangle of three indices, the last flagged by tlast. The output
// port moves one index per cycle while m_axis_tready is high, so a steady
// stream of strip or fan vertices drains slower than a list stream; the
// queue lets input run ahead while output is stalled. Indices at or above
// vertex_count (cfg_data, reset 65536) come out as zero. Write cfg_data only
// while the block is idle.
// ----------------------------------------------------------------------------
module strip_fan_to_triangle_list import sfl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input events
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [STDataBits-1:0] s_axis_tdata,  // prim_mode, vertex_index, zero pad
	input  logic [STUserBits-1:0] s_axis_tuser,  // opcode, index_present
	// output index list
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [MTDataBits-1:0] m_axis_tdata,  // out_index, zero pad
	output logic                  m_axis_tlast,
	// vertex_count register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CountBits-1:0]  cfg_data
);

	sfl_entry_t           push_entry;
	sfl_entry_t           head;
	sfl_qstat_t           qstat;
	logic                 push;
	logic                 pop;
	logic [IndexBits-1:0] out_index;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = MTDataBits'(out_index);

	// Event decode and primitive state
	sfl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.opcode        (s_axis_tuser[1:0]),
		.prim_mode     (s_axis_tdata[1:0]),
		.vertex_index  (s_axis_tdata[IndexBits+1:2]),
		.index_present (s_axis_tuser[2]),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_value     (cfg_data),
		.qstat         (qstat),
		.push          (push),
		.push_entry    (push_entry)
	);

	// Job queue
	sfl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// Output sequencer
	sfl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_index   (out_index),
		.last_of_run (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// no job written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("job queue overflow");

	// no job taken from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("job queue underflow");

	// fill level never exceeds depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCntBits'(QDepth))
		else $error("job queue count out of range");

	// a stalled output index is not replaced by the sequencer
	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !pop)
		else $error("job popped while output stalled");
`endif

endmodule

@@ bench/tb_strip_fan_to_triangle_list.sv @@
// ----------------------------------------------------------------------------
// tb_strip_fan_to_triangle_list
// Self-checking bench for strip/fan/list primitive assembly.
// ----------------------------------------------------------------------------
// A queue of begin, vertex and end events is drained by a clocked driver onto
// the input stream. Every accepted event runs through a local model of the
// assembler, which queues the index list it should produce. A clocked monitor
// takes output transfers under random back-pressure and compares each index
// and tlast with the oldest queued expectation. The vertex count register is
// rewritten between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module tb_strip_fan_to_triangle_list;
	timeunit 1ns;
	timeprecision 1ps;

	import sfl_pkg::*;

	// Opcode with no meaning; the block must ignore it
	localparam logic [1:0] OpUnused = 2'd3;
	// Cycles allowed for in-flight work after the last result
	localparam int DrainCycles = 20;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [1:0]           mode;
		logic [IndexBits-1:0] idx;
		logic                 present;
	} prim_event_t;

	typedef struct packed {
		logic [IndexBits-1:0] idx;
		logic                 last;
	} list_index_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [STDataBits-1:0] s_axis_tdata = '0;  // prim_mode, vertex_index, zero pad
	logic [STUserBits-1:0] s_axis_tuser = '0;  // opcode, index_present
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [MTDataBits-1:0] m_axis_tdata;      // out_index, zero pad
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CountBits-1:0]  cfg_data = '0;

	prim_event_t pending_events[$];
	list_index_t expected_indices[$];
	prim_event_t in_flight;
	int          errors = 0;
	bit          steady_tx = 1'b0;
	bit          steady_rx = 1'b0;

	// Local copy of the assembler state
	logic [CountBits-1:0]  asm_vcount = CountBits'(1 << IndexBits);
	logic [1:0]            asm_mode = ModeOther;
	logic [1:0]            asm_held = 2'd0;
	logic [IndexBits-1:0]  asm_first = '0;
	logic [IndexBits-1:0]  asm_second = '0;
	logic                  asm_parity = 1'b0;

	strip_fan_to_triangle_list dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Update the local assembler with one accepted event, queue its output
	task automatic assemble_triangles(input prim_event_t ev);
		logic [IndexBits-1:0] sid;
		if (ev.opcode == OpBegin) begin
			asm_mode = ev.mode;
			asm_held = 2'd0;
		end else if (ev.opcode == OpEnd) begin
			asm_held = 2'd0;
		end else if (ev.opcode == OpVertex && ev.present) begin
			sid = ({1'b0, ev.idx} >= asm_vcount) ? '0 : ev.idx;
			if (asm_mode == ModeList) begin
				expected_indices.push_back('{sid, 1'b1});
			end else if (asm_mode == ModeStrip || asm_mode == ModeFan) begin
				if (asm_held < 2'd2) begin
					if (asm_held == 2'd0)
						asm_first = sid;
					else
						asm_second = sid;
					asm_held = asm_held + 2'd1;
					if (asm_mode == ModeStrip)
						asm_parity = 1'b0;
				end else begin
					expected_indices.push_back('{asm_first, 1'b0});
					expected_indices.push_back('{asm_second, 1'b0});
					expected_indices.push_back('{sid, 1'b1});
					// strip alternates the replaced vertex, fan keeps the hub
					if (asm_mode == ModeStrip) begin
						if (!asm_parity)
							asm_first = sid;
						else
							asm_second = sid;
						asm_parity = ~asm_parity;
					end else begin
						asm_second = sid;
					end
				end
			end
		end
	endtask

	// Driver: hold tvalid until transfer, then maybe idle, then next event
	always @(posedge clk) begin : driver
		bit busy;
		if (arst_n) begin
			busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				assemble_triangles(in_flight);
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_events.size() > 0 &&
				    (steady_tx || $urandom_range(99) >= 24)) begin
					in_flight = pending_events.pop_front();
					s_axis_tdata  <= STDataBits'({in_flight.idx, in_flight.mode});
					s_axis_tuser  <= {in_flight.present, in_flight.opcode};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transfer, randomize tready
	always @(posedge clk) begin : monitor
		list_index_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_indices.size() == 0) begin
					$display("%t unexpected output: index %0d last %0b", $time,
						m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					want = expected_indices.pop_front();
					if (m_axis_tdata !== MTDataBits'(want.idx) ||
					    m_axis_tlast !== want.last) begin
						$display("%t mismatch: expected index %0d last %0b, %s %0d last %0b",
							$time, want.idx, want.last, "got index",
							m_axis_tdata, m_axis_tlast);
						errors++;
					end
				end
			end
			m_axis_tready <= steady_rx || ($urandom_range(99) >= 24);
		end
	end

	task automatic push_event(input logic [1:0] op, input logic [1:0] mode,
			input logic [IndexBits-1:0] idx, input logic present);
		prim_event_t ev;
		ev = '{op, mode, idx, present};
		pending_events.push_back(ev);
	endtask

	// Index biased toward the vertex count boundary and the extremes
	function automatic logic [IndexBits-1:0] pick_index();
		int v;
		case ($urandom_range(3))
			0: v = $urandom_range((1 << IndexBits) - 1);
			1: v = int'(asm_vcount) + $urandom_range(2) - 1;
			2: v = $urandom_range(15);
			default: v = $urandom_range(1) ? (1 << IndexBits) - 1 : 0;
		endcase
		if (v < 0)
			v = 0;
		if (v > (1 << IndexBits) - 1)
			v = (1 << IndexBits) - 1;
		return IndexBits'(v);
	endfunction

	// Mostly whole primitives with random content, some loose noise
	task automatic queue_random_phase(input int n);
		int count;
		int nv;
		int r;
		logic [1:0] mode;
		count = 0;
		while (count < n) begin
			if ($urandom_range(99) < 82) begin
				r = $urandom_range(99);
				mode = (r < 25) ? ModeList : (r < 60) ? ModeStrip :
				       (r < 90) ? ModeFan : ModeOther;
				push_event(OpBegin, mode, IndexBits'($urandom), 1'($urandom));
				nv = $urandom_range(1, 9);
				for (int i = 0; i < nv; i++)
					push_event(OpVertex, 2'($urandom), pick_index(), $urandom_range(99) < 90);
				count += nv + 1;
				if ($urandom_range(99) < 85) begin
					push_event(OpEnd, 2'($urandom), IndexBits'($urandom), 1'($urandom));
					count++;
				end
			end else begin
				push_event(2'($urandom), 2'($urandom), pick_index(), 1'($urandom));
				count++;
			end
		end
	endtask

	// Block is drained: no pending input, nothing expected, pipeline settled
	task automatic wait_drained();
		@(negedge clk);
		while (pending_events.size() != 0 || s_axis_tvalid || expected_indices.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [CountBits-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		asm_vcount = value;
	endtask

	// Main sequence
	initial begin
		logic [CountBits-1:0] counts[6];
		counts = '{CountBits'(1000), CountBits'(0), CountBits'(1 << IndexBits),
			CountBits'(1), CountBits'((1 << IndexBits) - 1),
			CountBits'($urandom_range(1 << IndexBits))};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: list extremes, ignored events, strip, fan, other mode
		push_event(OpBegin, ModeList, 16'd0, 1'b0);
		push_event(OpVertex, ModeList, 16'd0, 1'b1);
		push_event(OpVertex, ModeOther, 16'hFFFF, 1'b1);
		push_event(OpVertex, ModeList, 16'd1234, 1'b0);
		push_event(OpUnused, ModeOther, 16'hFFFF, 1'b1);
		push_event(OpBegin, ModeStrip, 16'hFFFF, 1'b1);
		for (int i = 0; i < 5; i++)
			push_event(OpVertex, ModeList, IndexBits'(10 + i), 1'b1);
		push_event(OpEnd, ModeFan, 16'h5A5A, 1'b1);
		// strip mode survives end, parity restarts
		for (int i = 0; i < 3; i++)
			push_event(OpVertex, ModeList, IndexBits'(20 + i), 1'b1);
		push_event(OpBegin, ModeFan, 16'd0, 1'b0);
		for (int i = 0; i < 4; i++)
			push_event(OpVertex, ModeStrip, IndexBits'(30 + i), 1'b1);
		push_event(OpEnd, ModeList, 16'd0, 1'b0);
		push_event(OpVertex, ModeList, 16'd40, 1'b1);
		push_event(OpBegin, ModeOther, 16'd0, 1'b0);
		push_event(OpVertex, ModeList, 16'd50, 1'b1);
		push_event(OpVertex, ModeList, 16'd51, 1'b1);
		wait_drained();

		// random phases, each under its own vertex count
		for (int p = 0; p < 6; p++) begin
			write_vertex_count(counts[p]);
			steady_tx = (p == 2);
			steady_rx = (p == 2);
			queue_random_phase(75);
			wait_drained();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
